>>> src/ehtb_pkg.sv
package ehtb_pkg;

    localparam int HASH_W = 28;
    localparam int SYM_W  = 13;
    localparam int CNT_W  = 12;
    localparam int BKT_W  = 12;
    localparam int CFG_W  = 4;
    localparam int BYTE_W = 8;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic update;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_done;
    } t_dp_sts;

endpackage

>>> src/ehtb_ram.sv
module ehtb_ram #(
    parameter int WIDTH  = 25,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/ehtb_ctrl.sv
module ehtb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_last_byte,
    input  logic             i_stall,
    output logic             o_stall,
    output logic             o_valid,
    output ehtb_pkg::t_dp_cmd o_cmd,
    input  ehtb_pkg::t_dp_sts i_sts
);
    import ehtb_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_RUN    = 3'b010,
        ST_UPDATE = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;
    logic   out_free;
    logic   update;

    assign accept   = (r_state == ST_RUN) && i_valid;
    assign out_free = !r_out_valid || !i_stall;
    assign update   = (r_state == ST_UPDATE) && out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_sts.clear_done) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (accept && i_last_byte) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (out_free) begin
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    assign n_out_valid = update || (r_out_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall        = (r_state != ST_RUN);
    assign o_valid        = r_out_valid;
    assign o_cmd.clear_wr = (r_state == ST_CLEAR);
    assign o_cmd.accept   = accept;
    assign o_cmd.update   = update;

endmodule

>>> src/ehtb_datapath.sv
module ehtb_datapath #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ehtb_pkg::t_dp_cmd                 i_cmd,
    output ehtb_pkg::t_dp_sts                 o_sts,
    input  logic                              i_cfg_valid,
    input  logic [ehtb_pkg::CFG_W-1:0]        i_cfg_table_size_log2,
    input  logic [ehtb_pkg::BYTE_W-1:0]       i_name_byte,
    input  logic                              i_byte_valid,
    input  logic                              i_last_byte,
    input  logic [ehtb_pkg::SYM_W-1:0]        i_symbol_index,
    output logic [ehtb_pkg::HASH_W-1:0]       o_hash_value,
    output logic [ehtb_pkg::BKT_W-1:0]        o_bucket,
    output logic                              o_is_head,
    output logic [ehtb_pkg::SYM_W-1:0]        o_chain_slot,
    output logic [ehtb_pkg::SYM_W-1:0]        o_placed_symbol,
    output logic [ehtb_pkg::CNT_W-1:0]        o_bucket_collisions,
    output logic [ehtb_pkg::CNT_W-1:0]        o_max_collisions
);
    import ehtb_pkg::*;

    localparam int ADDR_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int LOG2_MAX = $clog2(TABLE_DEPTH + 1) - 1;
    localparam int ENTRY_W  = SYM_W + CNT_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);

    function automatic logic [HASH_W-1:0] fold_byte(input logic [HASH_W-1:0] h,
                                                    input logic [BYTE_W-1:0] c);
        logic [HASH_W+3:0] s;
        logic [3:0]        g;
        s = {h, 4'b0000} + {{(HASH_W-4){1'b0}}, c};
        g = s[HASH_W+3:HASH_W];
        return s[HASH_W-1:0] ^ {{(HASH_W-8){1'b0}}, g, 4'b0000};
    endfunction

    logic [CFG_W-1:0]   r_size_log2;
    logic [HASH_W-1:0]  r_hash;
    logic [CNT_W-1:0]   r_worst;
    logic [ADDR_W-1:0]  r_clr_addr;
    logic [HASH_W-1:0]  r_fin_hash;
    logic [SYM_W-1:0]   r_sym;
    logic [ADDR_W-1:0]  r_addr;
    logic [BKT_W-1:0]   r_bkt;

    logic [HASH_W-1:0]  r_o_hash;
    logic [BKT_W-1:0]   r_o_bucket;
    logic               r_o_is_head;
    logic [SYM_W-1:0]   r_o_chain_slot;
    logic [SYM_W-1:0]   r_o_placed;
    logic [CNT_W-1:0]   r_o_bucket_cnt;

    logic [HASH_W-1:0]  folded;
    logic [4:0]         k_cfg;
    logic [4:0]         k_eff;
    logic [HASH_W-1:0]  mask;
    logic [HASH_W-1:0]  masked;

    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [ENTRY_W-1:0] rd_data;

    logic [SYM_W-1:0]   tail;
    logic [CNT_W-1:0]   cnt;
    logic               head;
    logic [CNT_W-1:0]   new_cnt;
    logic [CNT_W-1:0]   n_worst;

    assign folded = i_byte_valid ? fold_byte(r_hash, i_name_byte) : r_hash;
    assign k_cfg  = {1'b0, r_size_log2};
    assign k_eff  = (k_cfg > 5'(LOG2_MAX)) ? 5'(LOG2_MAX) : k_cfg;
    assign mask   = (HASH_W'(1) << k_eff) - HASH_W'(1);
    assign masked = folded & mask;

    assign tail    = rd_data[ENTRY_W-1:CNT_W];
    assign cnt     = rd_data[CNT_W-1:0];
    assign head    = (tail == '0);
    assign new_cnt = (head || cnt == COUNT_MAX) ? cnt : cnt + CNT_W'(1);
    assign n_worst = (!head && new_cnt > r_worst) ? new_cnt : r_worst;

    assign wr_en   = i_cmd.clear_wr || i_cmd.update;
    assign wr_addr = i_cmd.clear_wr ? r_clr_addr : r_addr;
    assign wr_data = i_cmd.clear_wr ? '0 : {r_sym, new_cnt};

    assign o_sts.clear_done = (r_clr_addr == LAST_ADDR);

    ehtb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH),
        .ADDR_W(ADDR_W)
    ) u_table (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (i_cmd.accept),
        .i_rd_addr(masked[ADDR_W-1:0]),
        .o_rd_data(rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_log2 <= '0;
            r_hash      <= '0;
            r_worst     <= '0;
            r_clr_addr  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_size_log2 <= i_cfg_table_size_log2;
            end
            if (i_cmd.accept) begin
                r_hash <= i_last_byte ? '0 : folded;
            end
            if (i_cmd.update) begin
                r_worst <= n_worst;
            end
            if (i_cmd.clear_wr && !o_sts.clear_done) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_last_byte) begin
            r_fin_hash <= folded;
            r_sym      <= i_symbol_index;
            r_addr     <= masked[ADDR_W-1:0];
            r_bkt      <= masked[BKT_W-1:0];
        end
        if (i_cmd.update) begin
            r_o_hash       <= r_fin_hash;
            r_o_bucket     <= r_bkt;
            r_o_is_head    <= head;
            r_o_chain_slot <= head ? '0 : tail;
            r_o_placed     <= r_sym;
            r_o_bucket_cnt <= new_cnt;
        end
    end

    assign o_hash_value        = r_o_hash;
    assign o_bucket            = r_o_bucket;
    assign o_is_head           = r_o_is_head;
    assign o_chain_slot        = r_o_chain_slot;
    assign o_placed_symbol     = r_o_placed;
    assign o_bucket_collisions = r_o_bucket_cnt;
    assign o_max_collisions    = r_worst;

endmodule

>>> src/elf_hash_table_builder_top.sv
// Builds an ELF SysV symbol hash table from a stream of name bytes. Each transfer carries
// one name byte, which is folded into the 28-bit ELF hash when its byte-valid flag is set.
// A transfer marked as the last byte of a name also inserts the symbol: its bucket entry is
// read from the table memory when that byte is accepted and written back in the update
// state once the previous result has left the output; the input is stalled until then.
// The tail and count memory has a registered read, followed by this write-back.
// After reset the block clears all TABLE_DEPTH memory entries, one entry a cycle, and
// accepts no name bytes until that is done; configuration writes are taken at any time.
module elf_hash_table_builder_top #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ehtb_pkg::CFG_W-1:0]     i_cfg_table_size_log2,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [ehtb_pkg::BYTE_W-1:0]    i_name_byte,
    input  logic                           i_byte_valid,
    input  logic                           i_last_byte,
    input  logic [ehtb_pkg::SYM_W-1:0]     i_symbol_index,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [ehtb_pkg::HASH_W-1:0]    o_hash_value,
    output logic [ehtb_pkg::BKT_W-1:0]     o_bucket,
    output logic                           o_is_head,
    output logic [ehtb_pkg::SYM_W-1:0]     o_chain_slot,
    output logic [ehtb_pkg::SYM_W-1:0]     o_placed_symbol,
    output logic [ehtb_pkg::CNT_W-1:0]     o_bucket_collisions,
    output logic [ehtb_pkg::CNT_W-1:0]     o_max_collisions
);
    import ehtb_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    ehtb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_last_byte(i_last_byte),
        .i_stall    (i_stall),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    ehtb_datapath #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_sts                (sts),
        .i_cfg_valid          (i_cfg_valid),
        .i_cfg_table_size_log2(i_cfg_table_size_log2),
        .i_name_byte          (i_name_byte),
        .i_byte_valid         (i_byte_valid),
        .i_last_byte          (i_last_byte),
        .i_symbol_index       (i_symbol_index),
        .o_hash_value         (o_hash_value),
        .o_bucket             (o_bucket),
        .o_is_head            (o_is_head),
        .o_chain_slot         (o_chain_slot),
        .o_placed_symbol      (o_placed_symbol),
        .o_bucket_collisions  (o_bucket_collisions),
        .o_max_collisions     (o_max_collisions)
    );

endmodule

>>> verif/elf_hash_table_checker.sv
module elf_hash_table_checker #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [ehtb_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                        i_src_valid,
    input  logic                        i_src_stall,
    input  logic [ehtb_pkg::BYTE_W-1:0] i_name_byte,
    input  logic                        i_byte_valid,
    input  logic                        i_last_byte,
    input  logic [ehtb_pkg::SYM_W-1:0]  i_symbol_index,
    input  logic                        i_res_valid,
    input  logic                        i_res_stall,
    input  logic [ehtb_pkg::HASH_W-1:0] i_hash_value,
    input  logic [ehtb_pkg::BKT_W-1:0]  i_bucket,
    input  logic                        i_is_head,
    input  logic [ehtb_pkg::SYM_W-1:0]  i_chain_slot,
    input  logic [ehtb_pkg::SYM_W-1:0]  i_placed_symbol,
    input  logic [ehtb_pkg::CNT_W-1:0]  i_bucket_collisions,
    input  logic [ehtb_pkg::CNT_W-1:0]  i_max_collisions,
    output int                          o_mismatches,
    output int                          o_pending,
    output int                          o_checked
);
    import ehtb_pkg::*;

    typedef struct packed {
        logic [HASH_W-1:0] hash_value;
        logic [BKT_W-1:0]  bucket;
        logic              is_head;
        logic [SYM_W-1:0]  chain_slot;
        logic [SYM_W-1:0]  placed_symbol;
        logic [CNT_W-1:0]  bucket_collisions;
        logic [CNT_W-1:0]  max_collisions;
    } t_table_write;

    t_table_write      table_writes[$];
    logic [HASH_W-1:0] name_hash;
    logic [SYM_W-1:0]  tail_of[TABLE_DEPTH];
    logic [CNT_W-1:0]  collisions_of[TABLE_DEPTH];
    logic [CNT_W-1:0]  worst_collisions;
    logic [CFG_W-1:0]  size_log2;

    function automatic logic [HASH_W-1:0] elf_fold(input logic [HASH_W-1:0] h,
                                                   input logic [BYTE_W-1:0] c);
        logic [31:0] sum;
        sum = {h, 4'b0000} + {24'd0, c};
        return sum[27:0] ^ {20'd0, sum[31:28], 4'b0000};
    endfunction

    function automatic int unsigned bucket_mask(input logic [CFG_W-1:0] lg);
        int unsigned k;
        k = 32'(lg);
        while (k > 0 && (64'd1 << k) > TABLE_DEPTH) begin
            k--;
        end
        return (32'd1 << k) - 32'd1;
    endfunction

    task automatic absorb_byte(input logic [BYTE_W-1:0] nb, input logic bv,
                               input logic lb, input logic [SYM_W-1:0] sym);
        t_table_write w;
        int unsigned  b;
        logic [SYM_W-1:0] tail;
        if (bv) begin
            name_hash = elf_fold(name_hash, nb);
        end
        if (lb) begin
            b = name_hash & bucket_mask(size_log2);
            tail = tail_of[b];
            w.hash_value = name_hash;
            w.bucket = b[BKT_W-1:0];
            w.is_head = (tail == '0);
            w.chain_slot = w.is_head ? '0 : tail;
            w.placed_symbol = sym;
            if (!w.is_head) begin
                if (collisions_of[b] < COUNT_MAX) begin
                    collisions_of[b] = collisions_of[b] + CNT_W'(1);
                end
                if (collisions_of[b] > worst_collisions) begin
                    worst_collisions = collisions_of[b];
                end
            end
            tail_of[b] = sym;
            w.bucket_collisions = collisions_of[b];
            w.max_collisions = worst_collisions;
            table_writes.push_back(w);
            name_hash = '0;
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_table_write want;
        if (!i_rst_n) begin
            table_writes.delete();
            name_hash = '0;
            worst_collisions = '0;
            size_log2 = '0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                tail_of[i] = '0;
                collisions_of[i] = '0;
            end
            o_mismatches = 0;
            o_checked = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                size_log2 = i_cfg_data;
            end
            if (i_src_valid && !i_src_stall) begin
                absorb_byte(i_name_byte, i_byte_valid, i_last_byte, i_symbol_index);
            end
            if (i_res_valid && !i_res_stall) begin
                if (table_writes.size() == 0) begin
                    $error("Result transfer arrived with no table write expected");
                    o_mismatches++;
                end else begin
                    want = table_writes.pop_front();
                    check_field("hash_value", 32'(want.hash_value), 32'(i_hash_value));
                    check_field("bucket", 32'(want.bucket), 32'(i_bucket));
                    check_field("is_head", 32'(want.is_head), 32'(i_is_head));
                    check_field("chain_slot", 32'(want.chain_slot), 32'(i_chain_slot));
                    check_field("placed_symbol", 32'(want.placed_symbol),
                                32'(i_placed_symbol));
                    check_field("bucket_collisions", 32'(want.bucket_collisions),
                                32'(i_bucket_collisions));
                    check_field("max_collisions", 32'(want.max_collisions),
                                32'(i_max_collisions));
                    o_checked++;
                end
            end
        end
        o_pending = table_writes.size();
    end

endmodule

>>> verif/elf_hash_table_builder_top_tb.sv
module elf_hash_table_builder_top_tb;
    import ehtb_pkg::*;

    localparam int TABLE_DEPTH = 4096;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASE_ITEMS = 115;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CFG_W-1:0]  i_cfg_table_size_log2;
    logic              i_valid;
    logic              o_stall;
    logic [BYTE_W-1:0] i_name_byte;
    logic              i_byte_valid;
    logic              i_last_byte;
    logic [SYM_W-1:0]  i_symbol_index;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [HASH_W-1:0] o_hash_value;
    logic [BKT_W-1:0]  o_bucket;
    logic              o_is_head;
    logic [SYM_W-1:0]  o_chain_slot;
    logic [SYM_W-1:0]  o_placed_symbol;
    logic [CNT_W-1:0]  o_bucket_collisions;
    logic [CNT_W-1:0]  o_max_collisions;

    int mismatches;
    int pending;
    int checked;
    int n_items = 0;
    int n_sizes = 0;
    int stall_left = 0;
    int quiet_cycles = 0;
    bit idle_on = 1'b1;

    always #1 i_clk = ~i_clk;

    elf_hash_table_builder_top #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_table_size_log2(i_cfg_table_size_log2),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_name_byte(i_name_byte),
        .i_byte_valid(i_byte_valid),
        .i_last_byte(i_last_byte),
        .i_symbol_index(i_symbol_index),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_hash_value(o_hash_value),
        .o_bucket(o_bucket),
        .o_is_head(o_is_head),
        .o_chain_slot(o_chain_slot),
        .o_placed_symbol(o_placed_symbol),
        .o_bucket_collisions(o_bucket_collisions),
        .o_max_collisions(o_max_collisions)
    );

    elf_hash_table_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) table_checker (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_table_size_log2),
        .i_src_valid(i_valid),
        .i_src_stall(o_stall),
        .i_name_byte(i_name_byte),
        .i_byte_valid(i_byte_valid),
        .i_last_byte(i_last_byte),
        .i_symbol_index(i_symbol_index),
        .i_res_valid(o_valid),
        .i_res_stall(i_stall),
        .i_hash_value(o_hash_value),
        .i_bucket(o_bucket),
        .i_is_head(o_is_head),
        .i_chain_slot(o_chain_slot),
        .i_placed_symbol(o_placed_symbol),
        .i_bucket_collisions(o_bucket_collisions),
        .i_max_collisions(o_max_collisions),
        .o_mismatches(mismatches),
        .o_pending(pending),
        .o_checked(checked)
    );

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            i_stall <= 1'b1;
            stall_left <= $urandom_range(0, 5);
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("elf_hash_table_builder_top_tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [SYM_W-1:0] pick_symbol();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            return '0;
        end else if (r < 4) begin
            return SYM_W'($urandom_range(1, 8));
        end
        return SYM_W'($urandom_range(1, 4096));
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] nb, input logic bv, input logic lb,
                             input logic [SYM_W-1:0] sym);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_name_byte <= nb;
        i_byte_valid <= bv;
        i_last_byte <= lb;
        i_symbol_index <= sym;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        n_items++;
    endtask

    task automatic send_name(input int len, input logic [SYM_W-1:0] sym);
        if (len == 0) begin
            send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b1, sym);
        end else begin
            for (int i = 0; i < len; i++) begin
                send_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 9) != 0,
                          i == len - 1, (i == len - 1) ? sym : pick_symbol());
            end
        end
    endtask

    task automatic send_random_names(input int count);
        int stop_at;
        int r;
        stop_at = n_items + count;
        while (n_items < stop_at) begin
            r = $urandom_range(0, 19);
            if (r < 16) begin
                send_name($urandom_range(1, 12), pick_symbol());
            end else if (r < 18) begin
                send_name(0, pick_symbol());
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    send_byte(BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), pick_symbol());
                end
            end
        end
    endtask

    task automatic set_table_size(input logic [CFG_W-1:0] lg);
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_table_size_log2 <= lg;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        n_sizes++;
    endtask

    logic [CFG_W-1:0] phase_sizes[7] = '{4'd15, 4'd3, 4'd0, 4'd8, 4'd1, 4'd13, 4'd6};

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_table_size_log2 = '0;
        i_valid = 1'b0;
        i_name_byte = '0;
        i_byte_valid = 1'b0;
        i_last_byte = 1'b0;
        i_symbol_index = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty names open and then chain bucket zero; all-ones bytes exercise the
        // top-nibble fold; a skipped byte and symbol zero leave the bucket looking empty.
        set_table_size(4'd12);
        send_byte(8'h00, 1'b0, 1'b1, 13'd1);
        send_byte(8'hFF, 1'b0, 1'b1, 13'd2);
        for (int i = 0; i < 8; i++) begin
            send_byte(8'hFF, 1'b1, i == 7, (i == 7) ? 13'd4096 : pick_symbol());
        end
        send_byte("a", 1'b1, 1'b0, 13'd9);
        send_byte(8'hFF, 1'b0, 1'b0, 13'd9);
        send_byte("b", 1'b1, 1'b1, 13'd0);
        send_byte("a", 1'b1, 1'b0, 13'd4095);
        send_byte("b", 1'b1, 1'b1, 13'd5);
        send_byte(8'h00, 1'b1, 1'b1, 13'd3);
        send_byte(8'h80, 1'b1, 1'b1, 13'd7);
        send_byte(8'h7F, 1'b1, 1'b1, 13'd4095);

        foreach (phase_sizes[p]) begin
            set_table_size(phase_sizes[p]);
            send_random_names(PHASE_ITEMS);
        end

        // A single bucket takes a long run of insertions back to back, with no idling.
        idle_on = 1'b0;
        set_table_size(4'd0);
        for (int i = 0; i < 70; i++) begin
            send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b1, SYM_W'(i + 1));
        end
        send_random_names(20);

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (16) @(negedge i_clk);

        $display("Run covered %0d name byte transfers and %0d table writes over %0d table sizes,",
                 n_items, checked, n_sizes);
        $display("including empty names, symbol zero, oversized tables and long chains.");
        if (mismatches == 0) begin
            $display("elf_hash_table_builder_top_tb: PASS");
        end else begin
            $display("elf_hash_table_builder_top_tb: FAIL");
        end
        $finish;
    end

endmodule
